FILE: src/assert_macros.svh
// assertion macros for the rtl of the chunk framer, included only by hcf_emit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property checked on every rising edge outside of reset
`define HCF_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("hcf assertion failed");
// same-cycle implication checked outside of reset
`define HCF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hcf implication failed");
`else
`define HCF_ASSERT(label, clk, rst_n, prop)
`define HCF_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: src/hcf_pkg.sv
// types, codes and helpers of the chunk framer
`default_nettype none
package hcf_pkg;

	localparam int MaxBurst = 6;
	localparam int BurstCntW = 3;
	localparam int CfgIdxW = 1;
	localparam int CfgDataW = 17;

	localparam logic [0:0] CMD_START = 1'b0;
	localparam logic [0:0] CMD_DATA = 1'b1;

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_NO_ROOM = 2'd1;
	localparam logic [1:0] STATUS_SEQ_ERR = 2'd2;

	localparam logic [CfgIdxW-1:0] REG_OUT_CAPACITY = 1'd0;
	localparam logic [CfgIdxW-1:0] REG_HEX_UPPER = 1'd1;

	localparam logic [16:0] CAPACITY_RESET = 17'd65543;
	localparam logic HEX_UPPER_RESET = 1'b1;

	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [16:0] TRAILER_BYTES = 17'd4;

	// one result beat
	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic [1:0] status;
		logic       last;
	} result_t;

	// all results caused by one input beat
	typedef struct packed {
		result_t [MaxBurst-1:0] slot;
		logic [BurstCntW-1:0]   count;
	} burst_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
		logic [7:0] base;
		base = upper ? CH_UPPER_A : CH_LOWER_A;
		if (nib < 4'd10) begin
			hex_char = CH_ZERO + {4'd0, nib};
		end else begin
			hex_char = base + {4'd0, nib - 4'd10};
		end
	endfunction

endpackage
`default_nettype wire

FILE: src/hcf_frame_ctl.sv
// chunk state, configuration registers and per-beat result builder
`default_nettype none
module hcf_frame_ctl (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [hcf_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [hcf_pkg::CfgDataW-1:0] cfg_wdata,
	input  wire logic                         item_fire,
	input  wire logic                         command,
	input  wire logic [15:0]                  chunk_length,
	input  wire logic [7:0]                   data_byte,
	output hcf_pkg::burst_t                   burst
);

	logic [16:0] capacity_q;
	logic        hex_upper_q;
	logic [15:0] remaining_q;
	logic        open_q;

	logic [2:0]  digits;
	logic [15:0] shifted;
	logic [16:0] framed;
	logic        too_large;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= hcf_pkg::CAPACITY_RESET;
			hex_upper_q <= hcf_pkg::HEX_UPPER_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				hcf_pkg::REG_OUT_CAPACITY: capacity_q <= cfg_wdata;
				hcf_pkg::REG_HEX_UPPER:    hex_upper_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// hex digit count and framed size check
	always_comb begin
		if (chunk_length[15:12] != 4'd0) begin
			digits = 3'd4;
		end else if (chunk_length[11:8] != 4'd0) begin
			digits = 3'd3;
		end else if (chunk_length[7:4] != 4'd0) begin
			digits = 3'd2;
		end else begin
			digits = 3'd1;
		end
		shifted = chunk_length << {3'd4 - digits, 2'b00};
		framed = {1'b0, chunk_length} + hcf_pkg::TRAILER_BYTES + {14'd0, digits};
		too_large = framed > capacity_q;
	end

	// results for the beat at the input
	always_comb begin
		burst = '0;
		if (command == hcf_pkg::CMD_START) begin
			if (open_q) begin
				burst.slot[0].status = hcf_pkg::STATUS_SEQ_ERR;
				burst.count = 3'd1;
			end else if (too_large) begin
				burst.slot[0].status = hcf_pkg::STATUS_NO_ROOM;
				burst.count = 3'd1;
			end else begin
				for (int k = 0; k < 4; k++) begin
					if (3'(k) < digits) begin
						burst.slot[k].data = hcf_pkg::hex_char(shifted[15-4*k -: 4], hex_upper_q);
						burst.slot[k].valid = 1'b1;
					end
				end
				burst.slot[digits].data = hcf_pkg::CH_CR;
				burst.slot[digits].valid = 1'b1;
				burst.slot[digits + 3'd1].data = hcf_pkg::CH_LF;
				burst.slot[digits + 3'd1].valid = 1'b1;
				burst.count = digits + 3'd2;
				// empty chunk closes right away
				if (chunk_length == 16'd0) begin
					burst.slot[3].data = hcf_pkg::CH_CR;
					burst.slot[3].valid = 1'b1;
					burst.slot[4].data = hcf_pkg::CH_LF;
					burst.slot[4].valid = 1'b1;
					burst.count = 3'd5;
				end
			end
		end else begin
			if (!open_q) begin
				burst.slot[0].status = hcf_pkg::STATUS_SEQ_ERR;
				burst.count = 3'd1;
			end else begin
				burst.slot[0].data = data_byte;
				burst.slot[0].valid = 1'b1;
				burst.count = 3'd1;
				// final payload byte gets the trailer
				if (remaining_q == 16'd1) begin
					burst.slot[1].data = hcf_pkg::CH_CR;
					burst.slot[1].valid = 1'b1;
					burst.slot[2].data = hcf_pkg::CH_LF;
					burst.slot[2].valid = 1'b1;
					burst.count = 3'd3;
				end
			end
		end
		burst.slot[burst.count - 3'd1].last = 1'b1;
	end

	// chunk state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remaining_q <= '0;
			open_q <= 1'b0;
		end else if (item_fire) begin
			if (command == hcf_pkg::CMD_START) begin
				if (!open_q && !too_large && chunk_length != 16'd0) begin
					open_q <= 1'b1;
					remaining_q <= chunk_length;
				end
			end else if (open_q) begin
				remaining_q <= remaining_q - 16'd1;
				if (remaining_q == 16'd1) begin
					open_q <= 1'b0;
				end
			end
		end
	end

endmodule
`default_nettype wire

FILE: src/hcf_emit.sv
// result register that plays out one burst a beat at a time
`default_nettype none
`include "assert_macros.svh"
module hcf_emit (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            load,
	input  wire hcf_pkg::burst_t burst,
	output logic                 room,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output logic [7:0]           m_tdata,
	output logic [2:0]           m_tuser,
	output logic                 m_tlast
);

	hcf_pkg::result_t [hcf_pkg::MaxBurst-1:0] slot_q;
	logic [hcf_pkg::BurstCntW-1:0] cnt_q;
	logic [hcf_pkg::BurstCntW-1:0] rd_q;
	hcf_pkg::result_t cur;
	logic fire;

	assign cur = slot_q[rd_q];
	assign m_tvalid = cnt_q != '0;
	assign fire = m_tvalid && m_tready;
	// free when empty or when the final beat leaves now
	assign room = (cnt_q == '0) || (cnt_q == 3'd1 && m_tready);

	assign m_tdata = cur.data;
	assign m_tuser = {cur.status, cur.valid};
	assign m_tlast = cur.last;

	// burst payload
	always_ff @(posedge clk) begin
		if (load) begin
			slot_q <= burst.slot;
		end
	end

	// read pointer and beats left
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q <= '0;
		end else if (load) begin
			cnt_q <= burst.count;
			rd_q <= '0;
		end else if (fire) begin
			cnt_q <= cnt_q - 3'd1;
			rd_q <= rd_q + 3'd1;
		end
	end

	`HCF_ASSERT_IMPL(a_load_only_when_free, clk, arst_n, load, cnt_q == '0 || (cnt_q == 3'd1 && fire))
	`HCF_ASSERT_IMPL(a_last_on_final, clk, arst_n, m_tvalid && cnt_q == 3'd1, m_tlast)
	`HCF_ASSERT_IMPL(a_no_early_last, clk, arst_n, m_tvalid && cnt_q > 3'd1, !m_tlast)
	`HCF_ASSERT(a_cnt_bound, clk, arst_n, {1'b0, cnt_q} + {1'b0, rd_q} <= 4'(hcf_pkg::MaxBurst))

endmodule
`default_nettype wire

FILE: src/http_chunk_framer_core.sv
// top level of the http chunk framer
//
// channel  dir  tdata (low bit up)            tuser (low bit up)          tlast
// s_*      in   chunk_length[15:0], data_byte command                     -
// m_*      out  out_byte                      byte_valid, status[1:0]     last
// cfg_*    in   write enable, index, data (17 bits), no read-back
//
// one input beat is taken per cycle while each beat yields one result (payload mid-chunk)
// a beat yielding n results (n up to 6) holds the input while the burst register plays them out
// the next beat is taken in the cycle the final result of the previous one leaves
// m_tready low stalls the burst register and with it the input
// arst_n clears chunk state and loads register reset values
`default_nettype none
module http_chunk_framer_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [23:0]                  s_tdata,  // chunk_length, data_byte
	input  wire logic                         s_tuser,  // command
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [7:0]                        m_tdata,  // out_byte
	output logic [2:0]                        m_tuser,  // byte_valid, status
	output logic                              m_tlast,
	input  wire logic                         cfg_we,
	input  wire logic [hcf_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [hcf_pkg::CfgDataW-1:0] cfg_wdata
);

	hcf_pkg::burst_t burst;
	logic room;
	logic item_fire;

	assign s_tready = room;
	assign item_fire = s_tvalid && room;

	// chunk state and result builder
	hcf_frame_ctl u_ctl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.item_fire    (item_fire),
		.command      (s_tuser),
		.chunk_length (s_tdata[15:0]),
		.data_byte    (s_tdata[23:16]),
		.burst        (burst)
	);

	// result register and output sequencing
	hcf_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (item_fire),
		.burst    (burst),
		.room     (room),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

FILE: test/tb_top.sv
// testbench for the http chunk framer: directed and random beat streams checked by a framing model
`timescale 1ns / 1ps
module tb_top;

	localparam int StallLimit = 1000;
	localparam int HexDigitsMax = 4;
	localparam int RandomPhases = 6;
	localparam int BeatsPerPhase = 58;
	localparam int TailPayload = 8;

	logic                         clk;
	logic                         arst_n;
	logic                         s_tvalid;
	logic                         s_tready;
	logic [23:0]                  s_tdata;   // chunk_length[15:0], data_byte[23:16]
	logic                         s_tuser;   // command
	logic                         m_tvalid;
	logic                         m_tready;
	logic [7:0]                   m_tdata;   // out_byte
	logic [2:0]                   m_tuser;   // byte_valid, status[1:0]
	logic                         m_tlast;
	logic                         cfg_we;
	logic [hcf_pkg::CfgIdxW-1:0]  cfg_index;
	logic [hcf_pkg::CfgDataW-1:0] cfg_wdata;

	// framing model: chunk state and register copies
	logic             chunk_is_open;
	logic [15:0]      payload_left;
	logic [16:0]      cap_bytes;
	logic             upper_hex;
	hcf_pkg::result_t framed_q[$];

	logic item_seen;
	logic idle_on;
	int   ready_hold;
	int   quiet_cycles;
	int   err_count;

	http_chunk_framer_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// clock
	always #5 clk = ~clk;

	// ascii hex digit in the configured letter case
	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		if (nib < 4'd10) return hcf_pkg::CH_ZERO + 8'(nib);
		return (upper_hex ? hcf_pkg::CH_UPPER_A : hcf_pkg::CH_LOWER_A) + 8'(nib - 4'd10);
	endfunction

	function automatic void push_beat(input logic [7:0] b, input logic v,
			input logic [1:0] st, input logic l);
		hcf_pkg::result_t r;
		r.data = b;
		r.valid = v;
		r.status = st;
		r.last = l;
		framed_q.push_back(r);
	endfunction

	// expected output beats for one input beat, updates the chunk state
	task automatic frame_item(input logic cmd, input logic [15:0] len, input logic [7:0] dbyte);
		int digits;
		int framed;
		if (cmd == hcf_pkg::CMD_START) begin
			if (chunk_is_open) begin
				push_beat(8'd0, 1'b0, hcf_pkg::STATUS_SEQ_ERR, 1'b1);
				return;
			end
			digits = 1;
			while (digits < HexDigitsMax && (len >> (4 * digits)) != 0) digits++;
			framed = int'(len) + int'(hcf_pkg::TRAILER_BYTES) + digits;
			if (framed > int'(cap_bytes)) begin
				push_beat(8'd0, 1'b0, hcf_pkg::STATUS_NO_ROOM, 1'b1);
				return;
			end
			for (int i = digits; i > 0; i--)
				push_beat(hex_digit(4'(len >> (4 * (i - 1)))), 1'b1, hcf_pkg::STATUS_OK, 1'b0);
			push_beat(hcf_pkg::CH_CR, 1'b1, hcf_pkg::STATUS_OK, 1'b0);
			push_beat(hcf_pkg::CH_LF, 1'b1, hcf_pkg::STATUS_OK, len != 16'd0);
			if (len == 16'd0) begin
				// empty chunk closes at once
				push_beat(hcf_pkg::CH_CR, 1'b1, hcf_pkg::STATUS_OK, 1'b0);
				push_beat(hcf_pkg::CH_LF, 1'b1, hcf_pkg::STATUS_OK, 1'b1);
			end else begin
				chunk_is_open = 1'b1;
				payload_left = len;
			end
		end else if (!chunk_is_open) begin
			push_beat(8'd0, 1'b0, hcf_pkg::STATUS_SEQ_ERR, 1'b1);
		end else begin
			payload_left = payload_left - 16'd1;
			push_beat(dbyte, 1'b1, hcf_pkg::STATUS_OK, payload_left != 16'd0);
			if (payload_left == 16'd0) begin
				// final payload byte gets the trailing cr lf
				push_beat(hcf_pkg::CH_CR, 1'b1, hcf_pkg::STATUS_OK, 1'b0);
				push_beat(hcf_pkg::CH_LF, 1'b1, hcf_pkg::STATUS_OK, 1'b1);
				chunk_is_open = 1'b0;
			end
		end
	endtask

	// prediction on first sight of an input beat, output check, watchdog
	always @(posedge clk) begin
		hcf_pkg::result_t want;
		if (arst_n) begin
			if (s_tvalid && !item_seen) begin
				frame_item(s_tuser, s_tdata[15:0], s_tdata[23:16]);
				item_seen = 1'b1;
			end
			if (m_tvalid && m_tready) begin
				if (framed_q.size() == 0) begin
					$error("beat with nothing expected: out_byte %h", m_tdata);
					err_count++;
				end else begin
					want = framed_q.pop_front();
					if (m_tdata !== want.data) begin
						$error("out_byte: expected %h, got %h", want.data, m_tdata);
						err_count++;
					end
					if (m_tuser[0] !== want.valid) begin
						$error("byte_valid: expected %b, got %b", want.valid, m_tuser[0]);
						err_count++;
					end
					if (m_tuser[2:1] !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, m_tuser[2:1]);
						err_count++;
					end
					if (m_tlast !== want.last) begin
						$error("last: expected %b, got %b", want.last, m_tlast);
						err_count++;
					end
				end
			end
			if (s_tvalid && s_tready) item_seen = 1'b0;
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= StallLimit) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// output backpressure in short random bursts
	always @(negedge clk) begin
		if (ready_hold != 0) ready_hold--;
		else if (idle_on && $urandom_range(0, 5) == 0) ready_hold = $urandom_range(1, 3);
		m_tready <= (ready_hold == 0);
	end

	// present one beat, return at the falling edge after it is taken
	task automatic send_item(input logic cmd, input logic [15:0] len, input logic [7:0] dbyte);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {dbyte, len};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	// stop sending and let every expected beat arrive
	task automatic drain();
		s_tvalid <= 1'b0;
		while (framed_q.size() != 0 || item_seen) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// write both registers while the block is idle
	task automatic configure(input logic [16:0] cap, input logic upper);
		cfg_we <= 1'b1;
		cfg_index <= hcf_pkg::REG_OUT_CAPACITY;
		cfg_wdata <= cap;
		@(negedge clk);
		cfg_index <= hcf_pkg::REG_HEX_UPPER;
		cfg_wdata <= {16'd0, upper};
		@(negedge clk);
		cfg_we <= 1'b0;
		cap_bytes = cap;
		upper_hex = upper;
	endtask

	// out-of-order beats, empty chunk and a short chunk at reset settings
	task automatic test_sequence_errors();
		idle_on = 1'b1;
		send_item(hcf_pkg::CMD_DATA, 16'h0000, 8'h5a);
		send_item(hcf_pkg::CMD_START, 16'h0000, 8'h00);
		send_item(hcf_pkg::CMD_START, 16'h000a, 8'hff);
		send_item(hcf_pkg::CMD_DATA, 16'hffff, 8'h00);
		send_item(hcf_pkg::CMD_DATA, 16'h0000, 8'hff);
		send_item(hcf_pkg::CMD_START, 16'h0003, 8'h00);
		while (chunk_is_open) send_item(hcf_pkg::CMD_DATA, 16'($urandom), 8'($urandom));
	endtask

	// framed size right at the limit, one over it, and the register extremes
	task automatic test_capacity_limits();
		drain();
		configure(17'd6, 1'b0);
		send_item(hcf_pkg::CMD_START, 16'h0001, 8'h00);
		send_item(hcf_pkg::CMD_DATA, 16'h0000, 8'hc3);
		send_item(hcf_pkg::CMD_START, 16'h0002, 8'h00);
		send_item(hcf_pkg::CMD_START, 16'hffff, 8'hff);
		drain();
		configure(17'd0, 1'b1);
		send_item(hcf_pkg::CMD_START, 16'h0000, 8'h00);
		send_item(hcf_pkg::CMD_DATA, 16'h0000, 8'h81);
		drain();
		configure(17'h1ffff, 1'b1);
		send_item(hcf_pkg::CMD_START, 16'h0000, 8'h00);
	endtask

	// mostly well-formed chunks with random content, some out-of-order beats
	// chunk lengths stay within the beats still left in the random part
	task automatic random_item(input int budget);
		int pick;
		logic [15:0] len;
		pick = $urandom_range(0, 19);
		if (pick == 0) begin
			send_item(chunk_is_open ? hcf_pkg::CMD_START : hcf_pkg::CMD_DATA,
				16'($urandom), 8'($urandom));
		end else if (chunk_is_open) begin
			send_item(hcf_pkg::CMD_DATA, 16'($urandom), 8'($urandom));
		end else begin
			if (pick < 3) len = 16'd0;
			else if (pick < 5) len = 16'($urandom_range(16, 300));
			else if (pick < 8 && cap_bytes < 17'd320) len = 16'($urandom);
			else len = 16'($urandom_range(1, 24));
			if (int'(len) > budget) len = 16'(budget);
			send_item(hcf_pkg::CMD_START, len, 8'($urandom));
		end
	endtask

	task automatic test_random_streams();
		int cap_pick;
		logic [16:0] cap;
		for (int phase = 0; phase < RandomPhases; phase++) begin
			drain();
			cap_pick = $urandom_range(0, 9);
			if (cap_pick < 5) cap = hcf_pkg::CAPACITY_RESET;
			else if (cap_pick < 9) cap = 17'($urandom_range(5, 40));
			else if ($urandom_range(0, 1) == 0) cap = 17'd0;
			else cap = 17'h1ffff;
			configure(cap, 1'($urandom_range(0, 1)));
			// one phase mid-run and the final phase run without idling
			idle_on = (phase != 2) && (phase != RandomPhases - 1);
			for (int n = 0; n < BeatsPerPhase; n++)
				random_item((RandomPhases - phase) * BeatsPerPhase - n);
		end
	endtask

	// largest chunk length: four lower-case digits and the first payload bytes
	task automatic test_full_length_chunk();
		idle_on = 1'b0;
		while (chunk_is_open) send_item(hcf_pkg::CMD_DATA, 16'($urandom), 8'($urandom));
		drain();
		configure(hcf_pkg::CAPACITY_RESET, 1'b0);
		send_item(hcf_pkg::CMD_START, 16'hffff, 8'($urandom));
		repeat (TailPayload) send_item(hcf_pkg::CMD_DATA, 16'($urandom), 8'($urandom));
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = hcf_pkg::CMD_START;
		m_tready = 1'b1;
		cfg_we = 1'b0;
		cfg_index = hcf_pkg::REG_OUT_CAPACITY;
		cfg_wdata = '0;
		chunk_is_open = 1'b0;
		payload_left = 16'd0;
		cap_bytes = hcf_pkg::CAPACITY_RESET;
		upper_hex = hcf_pkg::HEX_UPPER_RESET;
		item_seen = 1'b0;
		idle_on = 1'b0;
		ready_hold = 0;
		quiet_cycles = 0;
		err_count = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_sequence_errors();
		test_capacity_limits();
		test_random_streams();
		test_full_length_chunk();
		drain();
		repeat (8) @(negedge clk);
		if (err_count == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

endmodule
